/* sv/hdrtm_pkg.sv */
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared types, codes and the gamma threshold table of the HDR accumulator.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

	localparam int ACC_W    = 48;
	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 12;
	localparam int SIZE_W   = 9;
	localparam int SCALE_W  = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IW   = 2;
	localparam int T_W      = 12;
	localparam int THR_W    = 13;
	localparam int DIV_STEPS = 12;
	localparam int GAM_STEPS = 8;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_TONE_SCALE   = 2'd2;

	typedef struct packed {
		logic [ACC_W-1:0] red;
		logic [ACC_W-1:0] green;
		logic [ACC_W-1:0] blue;
	} acc_rgb_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} sample_rgb_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb8_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_TONE,
		ST_POST
	} top_state_t;

	typedef enum logic [2:0] {
		TM_IDLE,
		TM_MUL,
		TM_SAT,
		TM_DIV,
		TM_GAM,
		TM_DONE
	} tm_state_t;

	typedef logic [255:0][THR_W-1:0] thr_tab_t;

	// Smallest t with t^5 * 510^11 >= 4096^5 * (2k-1)^11, for each output code k.
	function automatic thr_tab_t gamma_thr_table();
		thr_tab_t   tab;
		logic [191:0] c510;
		logic [191:0] rhs;
		logic [191:0] lhs;
		logic [12:0]  lo;
		logic [12:0]  hi;
		logic [12:0]  mid;
		logic [191:0] m;
		tab = '0;
		c510 = 192'd1;
		for (int i = 0; i < 11; i++) c510 = c510 * 192'd510;
		for (int k = 1; k < 256; k++) begin
			m = 192'(2 * k - 1);
			rhs = 192'd1 << 60;
			for (int i = 0; i < 11; i++) rhs = rhs * m;
			lo = 13'd0;
			hi = 13'd4096;
			for (int s = 0; s < 14; s++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					lhs = c510;
					for (int i = 0; i < 5; i++) lhs = lhs * 192'(mid);
					if (lhs >= rhs) hi = mid;
					else lo = mid + 13'd1;
				end
			end
			tab[k] = lo;
		end
		return tab;
	endfunction

	localparam thr_tab_t GAMMA_THR = gamma_thr_table();

endpackage

/* sv/hdrtm_accum.sv */
// ----------------------------------------------------------------------------
// hdrtm_accum
// Accumulator store: saturating read-modify-write add, pixel read, clear sweep.
// ----------------------------------------------------------------------------
module hdrtm_accum import hdrtm_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        add_go,
	input  logic        read_go,
	input  logic        clear_go,
	input  logic [AW-1:0] addr,
	input  sample_rgb_t sample,
	output logic        busy,
	output acc_rgb_t    rd_data
);

	acc_rgb_t mem [DEPTH];

	logic        clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic        add_s1;
	logic [AW-1:0] addr_s1;
	sample_rgb_t sample_s1;

	logic        wr_en;
	logic [AW-1:0] wr_addr;
	acc_rgb_t    wr_data;
	acc_rgb_t    sum;

	function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a,
			logic [SAMPLE_W-1:0] s);
		logic [ACC_W:0] r;
		r = {1'b0, a} + {{(ACC_W - SAMPLE_W + 1){1'b0}}, s};
		return r[ACC_W] ? {ACC_W{1'b1}} : r[ACC_W-1:0];
	endfunction

	assign busy = clr_q | add_s1;

	always_comb begin
		sum.red   = sat_add(rd_data.red, sample_s1.red);
		sum.green = sat_add(rd_data.green, sample_s1.green);
		sum.blue  = sat_add(rd_data.blue, sample_s1.blue);
		wr_en   = clr_q | add_s1;
		wr_addr = clr_q ? clr_cnt_q : addr_s1;
		wr_data = clr_q ? '0 : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			add_s1    <= 1'b0;
		end else begin
			add_s1 <= add_go;
			if (clear_go) begin
				clr_q     <= 1'b1;
				clr_cnt_q <= '0;
			end else if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_go) begin
			addr_s1   <= addr;
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (add_go | read_go) rd_data <= mem[addr];
	end

endmodule

/* sv/hdrtm_tonemap.sv */
// ----------------------------------------------------------------------------
// hdrtm_tonemap
// Iterative tone map of one pixel: exposure multiply, Reinhard divide, gamma.
// ----------------------------------------------------------------------------
module hdrtm_tonemap import hdrtm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  acc_rgb_t           acc,
	input  logic [SCALE_W-1:0] tone_scale,
	output logic               done,
	output rgb8_t              pix
);

	localparam logic [44:0] CAP  = 45'h1000_0000_0000;
	localparam logic [44:0] ONE  = 45'h0_0001_0000_0000;

	tm_state_t   state_q, state_n;
	logic [1:0]  ch_q;
	acc_rgb_t    acc_q;
	logic [47:0] ph_q;
	logic [63:0] pl_q;
	logic [44:0] rem_q;
	logic [44:0] den_q;
	logic [T_W-1:0] quo_q;
	logic [3:0]  cnt_q;
	logic [7:0]  lo_q, hi_q;
	rgb8_t       pix_q;

	logic [ACC_W-1:0] chan;
	logic [45:0] psum;
	logic [44:0] prod;
	logic [45:0] sh;
	logic        ge;
	logic [45:0] diff;
	logic [8:0]  mid9;
	logic [7:0]  mid;
	logic [7:0]  lo_n, hi_n;

	always_comb begin
		case (ch_q)
			2'd0:    chan = acc_q.red;
			2'd1:    chan = acc_q.green;
			default: chan = acc_q.blue;
		endcase
		psum = {2'b0, ph_q[11:0], 32'b0} + {2'b0, pl_q[43:0]};
		if (ph_q >= 48'd4096 || pl_q >= 64'h0000_1000_0000_0000 || psum > {1'b0, CAP})
			prod = CAP;
		else
			prod = psum[44:0];
		sh   = {rem_q, 1'b0};
		ge   = sh >= {1'b0, den_q};
		diff = sh - {1'b0, den_q};
		mid9 = {1'b0, lo_q} + {1'b0, hi_q} + 9'd1;
		mid  = mid9[8:1];
		lo_n = lo_q;
		hi_n = hi_q;
		if (lo_q < hi_q) begin
			if ({1'b0, quo_q} >= GAMMA_THR[mid]) lo_n = mid;
			else hi_n = mid - 8'd1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			TM_IDLE: if (start) state_n = TM_MUL;
			TM_MUL:  state_n = TM_SAT;
			TM_SAT:  state_n = TM_DIV;
			TM_DIV:  if (cnt_q == 4'(DIV_STEPS - 1)) state_n = TM_GAM;
			TM_GAM: begin
				if (cnt_q == 4'(GAM_STEPS - 1)) state_n = (ch_q == 2'd2) ? TM_DONE : TM_MUL;
			end
			TM_DONE: state_n = TM_IDLE;
			default: state_n = TM_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == TM_DONE;
		pix  = pix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= TM_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			TM_IDLE: begin
				acc_q <= acc;
				ch_q  <= 2'd0;
			end
			TM_MUL: begin
				ph_q <= 48'(chan[47:32]) * 48'(tone_scale);
				pl_q <= 64'(chan[31:0]) * 64'(tone_scale);
			end
			TM_SAT: begin
				rem_q <= prod;
				den_q <= prod + ONE;
				cnt_q <= 4'd0;
			end
			TM_DIV: begin
				rem_q <= ge ? diff[44:0] : sh[44:0];
				quo_q <= {quo_q[T_W-2:0], ge};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(DIV_STEPS - 1)) begin
					cnt_q <= 4'd0;
					lo_q  <= 8'd0;
					hi_q  <= 8'd255;
				end
			end
			TM_GAM: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(GAM_STEPS - 1)) begin
					case (ch_q)
						2'd0:    pix_q.red   <= lo_n;
						2'd1:    pix_q.green <= lo_n;
						default: pix_q.blue  <= lo_n;
					endcase
					ch_q <= ch_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/hdr_accumulate_tonemap_unit.sv */
// Add: the next word waits for the store's read-modify-write (read, then write back) to finish.
// Read: an in-image read runs fetch, tone map and post before the next word is taken; per
//   channel 1 multiply, 1 saturate, 12 divide steps and 8 gamma search steps in one
//   shared tone map unit, three channels in turn. A stalled result slot adds its stall.
// Clear and reset: a sweep over all MAX_WIDTH*MAX_HEIGHT entries (65536 by default) zeroes the
//   store one entry a cycle; no input word is taken meanwhile, configuration writes are.
// Reset is asynchronous, active low; registers return to width 256, height 256, scale 1.0.
// ----------------------------------------------------------------------------
// hdr_accumulate_tonemap_unit
// HDR accumulation buffer with Reinhard tone map and gamma 2.2 byte output.
// ----------------------------------------------------------------------------
module hdr_accumulate_tonemap_unit import hdrtm_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [POS_W-1:0]    pos_x,
	input  logic [POS_W-1:0]    pos_y,
	input  logic [SAMPLE_W-1:0] sample_red,
	input  logic [SAMPLE_W-1:0] sample_green,
	input  logic [SAMPLE_W-1:0] sample_blue,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_red,
	output logic [7:0]          out_green,
	output logic [7:0]          out_blue,
	output logic                pixel_valid
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration registers
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [SCALE_W-1:0] scale_q;

	top_state_t state_q, state_n;
	rgb8_t      res_q;
	logic       res_valid_q;

	logic       in_image;
	logic [23:0] addr_full;
	logic       take;
	logic       add_go, read_go, clear_go;
	logic       busy;
	acc_rgb_t   rd_data;
	sample_rgb_t sample;
	logic       tm_start;
	logic       tm_done;
	rgb8_t      tm_pix;
	logic       out_free;

	// a position counts only below both the register and the fixed maximum
	assign in_image = ({1'b0, pos_x} < {4'b0, width_q}) &&
	                  ({1'b0, pos_x} < 13'(MAX_WIDTH)) &&
	                  ({1'b0, pos_y} < {4'b0, height_q}) &&
	                  ({1'b0, pos_y} < 13'(MAX_HEIGHT));
	// row stride is the fixed maximum, not the configured width
	assign addr_full = 24'(pos_y) * 24'(MAX_WIDTH) + 24'(pos_x);

	assign take     = in_valid && in_ready;
	assign add_go   = take && cmd == CMD_ADD && in_image;
	assign read_go  = take && cmd == CMD_READ && in_image;
	assign clear_go = take && cmd == CMD_CLEAR;
	assign sample   = '{red: sample_red, green: sample_green, blue: sample_blue};
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
			scale_q  <= SCALE_W'(65536);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				CFG_TONE_SCALE:   scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// next state: a read walks fetch -> tone map -> post; an out-of-range read posts zeros
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && cmd == CMD_READ) state_n = in_image ? ST_FETCH : ST_POST;
			end
			ST_FETCH: state_n = ST_TONE;
			ST_TONE:  if (tm_done) state_n = ST_POST;
			ST_POST:  if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && !busy;
		tm_start = state_q == ST_FETCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_POST && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// hold the pending result, then load the output word once the slot frees
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take) begin
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == ST_TONE && tm_done) begin
			res_q       <= tm_pix;
			res_valid_q <= 1'b1;
		end
		if (state_q == ST_POST && out_free) begin
			out_red     <= res_q.red;
			out_green   <= res_q.green;
			out_blue    <= res_q.blue;
			pixel_valid <= res_valid_q;
		end
	end

	hdrtm_accum #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.add_go   (add_go),
		.read_go  (read_go),
		.clear_go (clear_go),
		.addr     (addr_full[AW-1:0]),
		.sample   (sample),
		.busy     (busy),
		.rd_data  (rd_data)
	);

	hdrtm_tonemap u_tonemap (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (tm_start),
		.acc        (rd_data),
		.tone_scale (scale_q),
		.done       (tm_done),
		.pix        (tm_pix)
	);

endmodule
